[sv/grid_graph_edge_builder_defines.svh]
// Assertion macros used by the checker file.
`ifndef GRID_GRAPH_EDGE_BUILDER_DEFINES_SVH
`define GRID_GRAPH_EDGE_BUILDER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define GGE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high.
`define GGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/gge_pkg.sv]
package gge_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int FRAC_BITS  = 4;

  localparam int PIX_W  = 8 + FRAC_BITS;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = 11;
  localparam int IDX_W  = 22;
  localparam int NODE_W = 20;

  localparam int S_TDATA_W = ((PIX_W + 7) / 8) * 8;
  localparam int EDGE_W    = IDX_W + 2 * NODE_W + PIX_W;
  localparam int M_TDATA_W = ((EDGE_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W  = 3;
  localparam int REG_SEL_BIT = 2;
  localparam int APB_DATA_W  = 32;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
  localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(2);

  // cycles after reset or a register write until the offsets are valid
  localparam int SETTLE_W = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(2);

  localparam int EDGE_KINDS = 4;

  // emission order of the edges that close at one pixel
  typedef enum logic [1:0] {
    EK_RIGHT,
    EK_UPRIGHT,
    EK_DOWN,
    EK_DOWNRIGHT
  } edge_kind_t;

  // position of each edge inside the four-slot group of an interior pixel
  localparam logic [1:0] SLOT_RIGHT     = 2'd0;
  localparam logic [1:0] SLOT_DOWN      = 2'd1;
  localparam logic [1:0] SLOT_DOWNRIGHT = 2'd2;
  localparam logic [1:0] SLOT_UPRIGHT   = 2'd3;

  typedef struct packed {
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic [IDX_W-1:0] offs0;
    logic [IDX_W-1:0] offs1;
    logic [IDX_W-1:0] offs2;
  } geom_t;

  typedef struct packed {
    logic [PIX_W-1:0]  c;
    logic [PIX_W-1:0]  left;
    logic [PIX_W-1:0]  above;
    logic [PIX_W-1:0]  up_left;
    logic [PIX_W-1:0]  upright;
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic [NODE_W-1:0] p;
    logic [NODE_W-1:0] qa;
    logic [NODE_W-1:0] qb;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0]  weight;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] node_a;
    logic [IDX_W-1:0]  index;
  } edge_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v < MIN_DIM) begin
      r = MIN_DIM;
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [EDGE_KINDS-1:0] edge_mask(input logic [COL_W-1:0] x,
                                                      input logic [ROW_W-1:0] y,
                                                      input logic [COL_W-1:0] wm1);
    logic [EDGE_KINDS-1:0] m;
    m               = '0;
    m[EK_RIGHT]     = (x != '0);
    m[EK_UPRIGHT]   = (y != '0) && (x != wm1);
    m[EK_DOWN]      = (y != '0);
    m[EK_DOWNRIGHT] = (y != '0) && (x != '0);
    return m;
  endfunction

endpackage

[sv/gge_ram.sv]
module gge_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/gge_cfg.sv]
module gge_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gge_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [gge_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [gge_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output gge_pkg::geom_t                   geom,
  output logic                             cfg_wr
);
  import gge_pkg::*;

  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [COL_W-1:0]  wm1;
  logic [ROW_W-1:0]  hm1;
  logic [ROW_W-1:0]  hm2;
  logic [NODE_W-1:0] area;
  logic [IDX_W-1:0]  wm1_3;
  logic [IDX_W-1:0]  wm1_5;
  logic [IDX_W-1:0]  prod;
  logic [IDX_W-1:0]  offs1;
  logic [IDX_W-1:0]  offs2;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[REG_SEL_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= RESET_WIDTH;
      height_reg <= RESET_HEIGHT;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
      REG_HEIGHT: prdata = APB_DATA_W'(height_reg);
    endcase
  end

  assign w_eff = clamp_dim(width_reg, DIM_W'(MAX_WIDTH));
  assign h_eff = clamp_dim(height_reg, DIM_W'(MAX_HEIGHT));
  assign wm1   = COL_W'(w_eff - DIM_W'(1));
  assign hm1   = ROW_W'(h_eff - DIM_W'(1));
  assign hm2   = ROW_W'(h_eff - MIN_DIM);

  assign area  = NODE_W'(wm1) * NODE_W'(hm2);
  assign wm1_3 = IDX_W'(wm1) + IDX_W'({wm1, 1'b0});
  assign wm1_5 = IDX_W'(wm1) + IDX_W'({wm1, 2'b00});

  // top-row block starts after four slots per interior pixel
  always_ff @(posedge clk) begin
    prod  <= IDX_W'({area, 2'b00});
    offs1 <= prod + wm1_3;
    offs2 <= prod + wm1_5;
  end

  always_comb begin
    geom.wm1   = wm1;
    geom.hm1   = hm1;
    geom.offs0 = prod;
    geom.offs1 = offs1;
    geom.offs2 = offs2;
  end

endmodule

[sv/gge_slot.sv]
module gge_slot (
  input  gge_pkg::pix_t      pix,
  input  gge_pkg::geom_t     geom,
  input  gge_pkg::edge_kind_t kind,
  output gge_pkg::edge_t     rec
);
  import gge_pkg::*;

  logic [COL_W-1:0]  xm1;
  logic [IDX_W-1:0]  x_ext;
  logic [IDX_W-1:0]  xm1_ext;
  logic [IDX_W-1:0]  y_ext;
  logic [IDX_W-1:0]  x3;
  logic [IDX_W-1:0]  xm1_3;
  logic [NODE_W-1:0] p_up;
  logic              is_top;
  logic              is_bot;
  logic              is_second;
  logic              is_lastc;

  assign xm1       = pix.x - COL_W'(1);
  assign x_ext     = IDX_W'(pix.x);
  assign xm1_ext   = IDX_W'(xm1);
  assign y_ext     = IDX_W'(pix.y);
  assign x3        = x_ext + IDX_W'({pix.x, 1'b0});
  assign xm1_3     = xm1_ext + IDX_W'({xm1, 1'b0});
  assign p_up      = pix.p - NODE_W'(geom.wm1) - NODE_W'(1);
  assign is_top    = (pix.y == '0);
  assign is_bot    = (pix.y == geom.hm1);
  assign is_second = (pix.y == ROW_W'(1));
  assign is_lastc  = (pix.x == geom.wm1);

  always_comb begin
    rec = '0;
    case (kind)
      EK_RIGHT: begin
        if (is_top) begin
          rec.index = geom.offs0 + xm1_3;
        end else if (is_bot) begin
          rec.index = geom.offs1 + IDX_W'({xm1, 1'b0});
        end else begin
          rec.index = IDX_W'({pix.qa - NODE_W'(1), SLOT_RIGHT});
        end
        rec.node_a = pix.p - NODE_W'(1);
        rec.node_b = pix.p;
        rec.weight = absdiff(pix.left, pix.c);
      end
      EK_UPRIGHT: begin
        if (is_bot) begin
          rec.index = geom.offs1 + IDX_W'({pix.x, 1'b0}) + IDX_W'(1);
        end else begin
          rec.index = IDX_W'({pix.qa, SLOT_UPRIGHT});
        end
        rec.node_a = pix.p;
        rec.node_b = p_up + NODE_W'(1);
        rec.weight = absdiff(pix.c, pix.upright);
      end
      EK_DOWN: begin
        if (is_lastc) begin
          rec.index = geom.offs2 + y_ext - IDX_W'(1);
        end else if (is_second) begin
          rec.index = geom.offs0 + x3 + IDX_W'(1);
        end else begin
          rec.index = IDX_W'({pix.qb, SLOT_DOWN});
        end
        rec.node_a = p_up;
        rec.node_b = pix.p;
        rec.weight = absdiff(pix.above, pix.c);
      end
      EK_DOWNRIGHT: begin
        if (is_second) begin
          rec.index = geom.offs0 + xm1_3 + IDX_W'(2);
        end else begin
          rec.index = IDX_W'({pix.qb - NODE_W'(1), SLOT_DOWNRIGHT});
        end
        rec.node_a = p_up - NODE_W'(1);
        rec.node_b = pix.p;
        rec.weight = absdiff(pix.up_left, pix.c);
      end
    endcase
  end

endmodule

[sv/grid_graph_edge_builder.sv]
// Grid-graph edge builder: takes gray pixels in raster order and emits, one
// edge per beat, every 8-connected edge that closes at the pixel (right,
// up-right, down, down-right, in that order), with tlast on the pixel's final
// edge. Interior pixels emit every kind, top-row pixels only right, and the first
// pixel of a frame emits nothing. Edges leave through a single output register
// and a pixel holds the edge stage until it has handed over all of them; the
// next pixel is taken in the cycle the current one hands over its last edge.
// The previous row lives in a line RAM with one read and one write per pixel;
// the up-right value read for one pixel is carried as the above value of the
// next, and the last pixel of a row prefetches column 0. The RAM needs no
// clearing. After reset and after every register write the block holds
// s_tready low while the slot offsets settle; a register write restarts the
// frame at pixel (0,0).
module grid_graph_edge_builder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [11:0] pixel_value
  input  logic [gge_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [21:0] edge_index, [41:22] node_a, [61:42] node_b, [73:62] edge_weight
  output logic [gge_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                             m_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gge_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [gge_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [gge_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import gge_pkg::*;

  geom_t                 geom;
  logic                  cfg_wr;
  logic [SETTLE_W-1:0]   settle;

  logic [COL_W-1:0]      x_cnt;
  logic [ROW_W-1:0]      y_cnt;
  logic [NODE_W-1:0]     p_cnt;
  logic [NODE_W-1:0]     qa_cnt;
  logic [NODE_W-1:0]     qb_cnt;
  logic                  last_col;
  logic                  last_row;

  logic                  accept;
  logic [COL_W-1:0]      raddr;
  logic [PIX_W-1:0]      ram_rdata;

  pix_t                  pix_in;
  pix_t                  s1_pix;
  pix_t                  cur_pix;
  logic                  s1_valid;
  logic                  s1_first;
  logic [EDGE_KINDS-1:0] s1_mask;
  logic [EDGE_KINDS-1:0] mask_rest;
  logic [PIX_W-1:0]      upright_q;
  edge_kind_t            kind;
  edge_t                 rec;
  logic                  out_free;
  logic                  emit;
  logic                  s1_done;

  gge_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom),
    .cfg_wr  (cfg_wr)
  );

  assign last_col = (x_cnt == geom.wm1);
  assign last_row = (y_cnt == geom.hm1);
  assign accept   = s_tvalid && s_tready;
  // end of row: fetch column 0 as the next row's first above value
  assign raddr    = last_col ? '0 : x_cnt + COL_W'(1);

  gge_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (accept),
    .waddr (x_cnt),
    .wdata (s_tdata[PIX_W-1:0]),
    .re    (accept),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // the RAM output still holds the previous pixel's read at accept time
  always_comb begin
    pix_in         = s1_pix;
    pix_in.c       = s_tdata[PIX_W-1:0];
    pix_in.left    = s1_pix.c;
    pix_in.above   = ram_rdata;
    pix_in.up_left = s1_pix.above;
    pix_in.upright = '0;
    pix_in.x       = x_cnt;
    pix_in.y       = y_cnt;
    pix_in.p       = p_cnt;
    pix_in.qa      = qa_cnt;
    pix_in.qb      = qb_cnt;
  end

  always_comb begin
    cur_pix         = s1_pix;
    cur_pix.upright = s1_first ? ram_rdata : upright_q;
  end

  always_comb begin
    if (s1_mask[EK_RIGHT]) begin
      kind = EK_RIGHT;
    end else if (s1_mask[EK_UPRIGHT]) begin
      kind = EK_UPRIGHT;
    end else if (s1_mask[EK_DOWN]) begin
      kind = EK_DOWN;
    end else begin
      kind = EK_DOWNRIGHT;
    end
  end

  gge_slot u_slot (
    .pix  (cur_pix),
    .geom (geom),
    .kind (kind),
    .rec  (rec)
  );

  assign mask_rest = s1_mask & ~(EDGE_KINDS'(1) << kind);
  assign out_free  = !m_tvalid || m_tready;
  assign emit      = s1_valid && (s1_mask != '0) && out_free;
  assign s1_done   = s1_valid && ((s1_mask == '0) || (emit && (mask_rest == '0)));
  assign s_tready  = (settle == '0) && (!s1_valid || s1_done);

  // position counters and settle timer
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SETTLE_CYCLES;
      x_cnt  <= '0;
      y_cnt  <= '0;
      p_cnt  <= '0;
      qa_cnt <= '0;
      qb_cnt <= '0;
    end else if (cfg_wr) begin
      settle <= SETTLE_CYCLES;
      x_cnt  <= '0;
      y_cnt  <= '0;
      p_cnt  <= '0;
      qa_cnt <= '0;
      qb_cnt <= '0;
    end else begin
      if (settle != '0) begin
        settle <= settle - SETTLE_W'(1);
      end
      if (accept) begin
        if (last_col) begin
          x_cnt <= '0;
          y_cnt <= last_row ? '0 : y_cnt + ROW_W'(1);
        end else begin
          x_cnt <= x_cnt + COL_W'(1);
        end
        if (last_col && last_row) begin
          p_cnt  <= '0;
          qa_cnt <= '0;
          qb_cnt <= '0;
        end else begin
          p_cnt <= p_cnt + NODE_W'(1);
          // interior bases: hold through the row end, where the row step
          // equals one column step
          if (!last_col && (y_cnt != '0)) begin
            qa_cnt <= qa_cnt + NODE_W'(1);
          end
          if (!last_col && (y_cnt > ROW_W'(1))) begin
            qb_cnt <= qb_cnt + NODE_W'(1);
          end
        end
      end
    end
  end

  // edge stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_first <= 1'b0;
      s1_mask  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      s1_first <= accept;
      if (accept) begin
        s1_valid <= 1'b1;
        s1_mask  <= edge_mask(x_cnt, y_cnt, geom.wm1);
      end else begin
        if (s1_done) begin
          s1_valid <= 1'b0;
        end
        if (emit) begin
          s1_mask <= mask_rest;
        end
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pix_in;
    end
    if (s1_valid) begin
      upright_q <= cur_pix.upright;
    end
    if (emit) begin
      m_tdata <= M_TDATA_W'({rec.weight, rec.node_b, rec.node_a, rec.index});
      m_tlast <= (mask_rest == '0);
    end
  end

endmodule

[sv/gge_checker.sv]
`include "grid_graph_edge_builder_defines.svh"

module gge_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [gge_pkg::M_TDATA_W-1:0]    m_tdata,
  input logic                             m_tlast,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic                             pready
);
  import gge_pkg::*;

  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  assign node_a = m_tdata[IDX_W +: NODE_W];
  assign node_b = m_tdata[IDX_W + NODE_W +: NODE_W];

  // a stalled beat keeps its edge
  `GGE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast), "edge beat changed under stall")

  // a register write restarts the frame and blocks pixels while offsets settle
  `GGE_ASSERT_NEXT(a_cfg_block, psel && penable && pwrite && pready,
    !s_tready, "pixel taken right after a register write")

  // an edge always joins two distinct pixels
  `GGE_ASSERT_NOW(a_distinct_nodes, m_tvalid,
    node_a != node_b, "edge with equal node indices")

endmodule

bind grid_graph_edge_builder gge_checker u_gge_checker (.*);

[bench/tb_grid_graph_edge_builder.sv]
`timescale 1ns / 1ps

module tb_grid_graph_edge_builder;
  import gge_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_WAIT    = 8;
  localparam int TAIL_WAIT      = 20;
  localparam int DIR_ROWS       = 27;

  typedef struct packed {
    edge_t e;
    logic  last;
  } edge_beat_t;

  typedef enum logic [1:0] {OP_PIXEL, OP_SET_WIDTH, OP_SET_HEIGHT} step_op_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} check_t;
  typedef enum logic [1:0] {PR_NONE, PR_HOLDOFF, PR_PAUSE} pressure_t;

  typedef struct packed {
    step_op_t         op;
    logic [PIX_W-1:0] value;
    check_t           chk;
    edge_beat_t       beat;
  } dir_row_t;

  // typed beats: '{'{weight, node_b, node_a, edge_index}, last}
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{OP_PIXEL, 12'hFFF, CHK_NONE, '0},
    '{OP_PIXEL, 12'h000, CHK_ONE, '{'{12'hFFF, 20'd1, 20'd0, 22'd1221768}, 1'b1}},
    '{OP_SET_WIDTH, 12'd3, CHK_MODEL, '0},
    '{OP_SET_HEIGHT, 12'd3, CHK_MODEL, '0},
    '{OP_PIXEL, 12'h000, CHK_NONE, '0},
    '{OP_PIXEL, 12'hFFF, CHK_MODEL, '0},
    '{OP_PIXEL, 12'h800, CHK_MODEL, '0},
    '{OP_PIXEL, 12'h7FF, CHK_MODEL, '0},
    '{OP_PIXEL, 12'h001, CHK_MODEL, '0},
    '{OP_PIXEL, 12'hFFE, CHK_MODEL, '0},
    '{OP_PIXEL, 12'h555, CHK_MODEL, '0},
    '{OP_PIXEL, 12'hAAA, CHK_MODEL, '0},
    '{OP_PIXEL, 12'h123, CHK_MODEL, '0},
    // frame wrapped back to the origin
    '{OP_PIXEL, 12'h0F0, CHK_NONE, '0},
    '{OP_PIXEL, 12'hF0F, CHK_MODEL, '0},
    // write in the middle of a row restarts the frame
    '{OP_SET_HEIGHT, 12'd2047, CHK_MODEL, '0},
    '{OP_PIXEL, 12'h456, CHK_NONE, '0},
    '{OP_PIXEL, 12'hABC, CHK_MODEL, '0},
    '{OP_SET_WIDTH, 12'd0, CHK_MODEL, '0},
    '{OP_PIXEL, 12'h000, CHK_NONE, '0},
    '{OP_PIXEL, 12'hFFF, CHK_MODEL, '0},
    '{OP_PIXEL, 12'h789, CHK_MODEL, '0},
    '{OP_PIXEL, 12'h876, CHK_MODEL, '0},
    '{OP_SET_WIDTH, 12'd2047, CHK_MODEL, '0},
    '{OP_SET_HEIGHT, 12'd0, CHK_MODEL, '0},
    '{OP_PIXEL, 12'h000, CHK_NONE, '0},
    '{OP_PIXEL, 12'hFFF, CHK_ONE, '{'{12'hFFF, 20'd1, 20'd0, 22'd0}, 1'b1}}
  };

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  grid_graph_edge_builder DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // shadow of the block: registers, line store, neighbors and position
  logic [DIM_W-1:0] width_reg = RESET_WIDTH;
  logic [DIM_W-1:0] height_reg = RESET_HEIGHT;
  logic [PIX_W-1:0] row_line [MAX_WIDTH] = '{default: '0};
  logic [PIX_W-1:0] left_pix = '0;
  logic [PIX_W-1:0] upleft_pix = '0;
  int               col = 0;
  int               row = 0;

  edge_beat_t pending_edges [$];
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         src_steady = 1'b0;
  bit         sink_steady = 1'b0;
  int         holdoff_asked = 0;
  int         holdoff_done = 0;
  int         stall_left = 0;

  function automatic int clamped_dim(input logic [DIM_W-1:0] v, input int top);
    if (v < 2) return 2;
    if (v > top) return top;
    return int'(v);
  endfunction

  function automatic logic [PIX_W-1:0] abs_step(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic edge_beat_t make_beat(input int slot, input int a, input int b,
                                           input logic [PIX_W-1:0] wt);
    edge_beat_t r;
    r.e.index  = IDX_W'(slot);
    r.e.node_a = NODE_W'(a);
    r.e.node_b = NODE_W'(b);
    r.e.weight = wt;
    r.last     = 1'b0;
    return r;
  endfunction

  // edges that close at this pixel, in order right, up-right, down, down-right
  function automatic void close_edges_at_pixel(input logic [PIX_W-1:0] c,
                                               output edge_beat_t beats [4],
                                               output int n);
    int w, h, x, y, wm1, offs0, offs1, offs2, p, slot;
    logic [PIX_W-1:0] above;
    w = clamped_dim(width_reg, MAX_WIDTH);
    h = clamped_dim(height_reg, MAX_HEIGHT);
    x = col;
    y = row;
    if (x >= w || y >= h) begin
      x = 0;
      y = 0;
    end
    wm1   = w - 1;
    offs0 = 4 * wm1 * (h - 2);
    offs1 = offs0 + 3 * wm1;
    offs2 = offs1 + 2 * wm1;
    p     = y * w + x;
    above = row_line[x];
    n     = 0;
    beats = '{default: '0};
    if (x >= 1) begin
      if (y == 0) slot = offs0 + 3 * (x - 1);
      else if (y == h - 1) slot = offs1 + 2 * (x - 1);
      else slot = ((y - 1) * wm1 + x - 1) * 4;
      beats[n] = make_beat(slot, p - 1, p, abs_step(left_pix, c));
      n++;
    end
    if (y >= 1 && x + 1 < w) begin
      if (y == h - 1) slot = offs1 + 2 * x + 1;
      else slot = ((y - 1) * wm1 + x) * 4 + 3;
      beats[n] = make_beat(slot, p, p - w + 1, abs_step(c, row_line[x + 1]));
      n++;
    end
    if (y >= 1) begin
      if (x == wm1) slot = offs2 + y - 1;
      else if (y == 1) slot = offs0 + 3 * x + 1;
      else slot = ((y - 2) * wm1 + x) * 4 + 1;
      beats[n] = make_beat(slot, p - w, p, abs_step(above, c));
      n++;
    end
    if (y >= 1 && x >= 1) begin
      if (y == 1) slot = offs0 + 3 * (x - 1) + 2;
      else slot = ((y - 2) * wm1 + x - 1) * 4 + 2;
      beats[n] = make_beat(slot, p - w - 1, p, abs_step(upleft_pix, c));
      n++;
    end
    if (n > 0) beats[n - 1].last = 1'b1;
    upleft_pix = above;
    row_line[x] = c;
    left_pix = c;
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col = x;
    row = y;
  endfunction

  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom_range(0, 4095));
  endfunction

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] v, input check_t chk,
                            input edge_beat_t typed);
    edge_beat_t beats [4];
    int n;
    int idle;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'(v);
    do @(posedge clk); while (!s_tready);
    close_edges_at_pixel(v, beats, n);
    if (chk == CHK_MODEL) begin
      for (int k = 0; k < n; k++) pending_edges.push_back(beats[k]);
    end else if (chk == CHK_ONE) begin
      pending_edges.push_back(typed);
    end
    idle = src_steady ? 0 : pick_idle_len();
    if (idle > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [DIM_W-1:0] value);
    drain_results();
    // a frame-origin pixel leaves no beat behind, so give it time to retire
    repeat (SETTLE_WAIT) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_WIDTH) width_reg = value;
    else height_reg = value;
    col = 0;
    row = 0;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(value))
      report_mismatch("register readback", value, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input int count, input pressure_t pressure);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    src_steady  = ($urandom_range(0, 3) == 0);
    sink_steady = ($urandom_range(0, 3) == 0);
    if (pressure == PR_HOLDOFF) holdoff_asked++;
    for (int i = 0; i < count; i++) begin
      if ((pressure == PR_PAUSE && i == count / 2) || $urandom_range(0, 39) == 0)
        drain_results();
      send_pixel(random_pixel(), CHK_MODEL, '0);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holdoff_asked != holdoff_done) begin
      holdoff_done <= holdoff_done + 1;
      stall_left   <= HOLDOFF_CYCLES;
      m_tready     <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!sink_steady) stall_left <= pick_idle_len();
    end
  end

  always @(posedge clk) begin
    edge_t      got;
    edge_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[EDGE_W-1:0];
      if (pending_edges.size() == 0) begin
        report_mismatch("edge_index of a beat with nothing pending", 0, got.index);
      end else begin
        want = pending_edges.pop_front();
        if (got.index !== want.e.index)
          report_mismatch("edge_index", want.e.index, got.index);
        if (got.node_a !== want.e.node_a)
          report_mismatch("node_a", want.e.node_a, got.node_a);
        if (got.node_b !== want.e.node_b)
          report_mismatch("node_b", want.e.node_b, got.node_b);
        if (got.weight !== want.e.weight)
          report_mismatch("edge_weight", want.e.weight, got.weight);
        if (m_tlast !== want.last)
          report_mismatch("last_edge", want.last, m_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    dir_row_t r;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      r = DIRECTED_ROWS[i];
      case (r.op)
        OP_PIXEL: begin
          send_pixel(r.value, r.chk, r.beat);
        end
        OP_SET_WIDTH: begin
          write_reg(REG_WIDTH, r.value[DIM_W-1:0]);
        end
        default: begin
          write_reg(REG_HEIGHT, r.value[DIM_W-1:0]);
        end
      endcase
    end

    run_phase(11'd2, 11'd2, 12, PR_NONE);
    run_phase(11'd3, 11'd3, 30, PR_NONE);
    run_phase(11'd4, 11'd4, 30, PR_HOLDOFF);
    run_phase(11'd0, 11'd0, 10, PR_NONE);
    run_phase(11'd1, 11'd2047, 30, PR_NONE);
    run_phase(11'd5, 11'd3, 25, PR_PAUSE);
    run_phase(11'd2047, 11'd2, 20, PR_NONE);
    run_phase(11'd1024, 11'd1024, 15, PR_NONE);
    run_phase(11'd6, 11'd4, 20, PR_NONE);
    run_phase(11'd1, 11'd1, 8, PR_NONE);
    repeat (2)
      run_phase(DIM_W'($urandom_range(2, 9)), DIM_W'($urandom_range(2, 6)), 20, PR_NONE);

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_edges.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
